// ----- design/ktbl_pkg.sv -----
// Shared types, codes and constants of the keyed token bucket limiter.
package ktbl_pkg;

    // Fixed field widths of the request and result transactions.
    localparam int NOW_W   = 48;
    localparam int AMT_W   = 32;
    localparam int RATE_W  = 24;
    localparam int WIN_W   = 32;
    localparam int TAKEN_W = 40;
    localparam int RES_W   = 32;
    localparam int KEY_W   = 8;
    localparam int CMD_W   = 2;
    localparam int SEL_W   = 2;
    localparam int STAT_W  = 2;

    // Configuration port geometry.
    localparam int NUM_CFG = 4;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int RIDX_W  = 3;

    // Microseconds per millisecond.
    localparam logic [9:0] US_PER_MS = 10'd1000;

    // Register reset values.
    localparam logic [RATE_W-1:0] RATE_RESET = 24'd1;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 32'd1000;

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_CONSUME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GRANT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_THROTTLED = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [RIDX_W-1:0] REG_RATE0 = 3'd0;
    localparam logic [RIDX_W-1:0] REG_WIN0  = 3'd1;
    localparam logic [RIDX_W-1:0] REG_RATE1 = 3'd2;
    localparam logic [RIDX_W-1:0] REG_WIN1  = 3'd3;
    localparam logic [RIDX_W-1:0] REG_RATE2 = 3'd4;
    localparam logic [RIDX_W-1:0] REG_WIN2  = 3'd5;
    localparam logic [RIDX_W-1:0] REG_RATE3 = 3'd6;
    localparam logic [RIDX_W-1:0] REG_WIN3  = 3'd7;

    typedef logic [NUM_CFG-1:0][RATE_W-1:0] rate_vec_t;
    typedef logic [NUM_CFG-1:0][WIN_W-1:0]  win_vec_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CREATE,
        OP_READ,
        OP_MUL_LD_REFILL,
        OP_MUL_LD_WAIT,
        OP_MUL_STEP,
        OP_DIV_LD_REFILL,
        OP_DIV_LD_WAIT,
        OP_DIV_STEP,
        OP_SETTLE,
        OP_DECIDE,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [SEL_W-1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic ignore;
        logic release_op;
        logic known;
        logic skip_refill;
        logic throttle;
        logic mul_done;
        logic div_done;
        logic div_ovf;
    } dp_stat_t;

endpackage

// ----- design/keyed_token_bucket_limiter.sv -----
// Top level of the keyed token bucket limiter.
//
// A request transaction is taken when start is high and busy is low; its single
// result appears on result_value, status and units_taken for exactly one cycle
// with done high, and must be taken then, since the block cannot be held off.
// The next request may be started in the same cycle that done is high. A request
// that is ignored or releases an unknown key goes from its check to the finish
// state; a known-key release reads its entry first; a consume or grant reads and
// settles its entry, refilling it by a multiply and divide unless the time since
// the last refill is negative or at least the window, and a throttled consume then
// works out its wait time. The longest request is set by the shared restoring
// divider, which retires one quotient bit per cycle: 24+FRAC_BITS steps for the
// refill and up to 32 steps for the wait time, plus a 32x16 multiplier that needs
// 3 steps at FRAC_BITS=16 before each division. Creating a new key writes one
// entry per counter. The bucket memory needs no clearing pass after reset.
module keyed_token_bucket_limiter
    import ktbl_pkg::*;
#(
    parameter int NUM_KEYS     = 256,
    parameter int NUM_COUNTERS = 4,
    parameter int FRAC_BITS    = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   command,
    input  logic [SEL_W-1:0]   counter_sel,
    input  logic [KEY_W-1:0]   key_slot,
    input  logic [NOW_W-1:0]   now_us,
    input  logic [AMT_W-1:0]   amount,
    output logic               done,
    output logic [RES_W-1:0]   result_value,
    output logic [STAT_W-1:0]  status,
    output logic [TAKEN_W-1:0] units_taken,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    rate_vec_t rate_vec;
    win_vec_t  win_vec;
    dp_cmd_t   dp_cmd;
    dp_stat_t  dp_stat;

    // Configuration registers.
    ktbl_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .rate_vec (rate_vec),
        .win_vec  (win_vec)
    );

    // Sequencer.
    ktbl_ctrl #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (dp_cmd),
        .stat  (dp_stat)
    );

    // Datapath.
    ktbl_dp #(
        .NUM_KEYS     (NUM_KEYS),
        .NUM_COUNTERS (NUM_COUNTERS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .command      (command),
        .counter_sel  (counter_sel),
        .key_slot     (key_slot),
        .now_us       (now_us),
        .amount       (amount),
        .rate_vec     (rate_vec),
        .win_vec      (win_vec),
        .result_value (result_value),
        .status       (status),
        .units_taken  (units_taken)
    );

endmodule

// ----- design/ktbl_regs.sv -----
// Configuration register file with its APB-style access port.
module ktbl_regs
    import ktbl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output rate_vec_t         rate_vec,
    output win_vec_t          win_vec
);

    rate_vec_t         rate_reg;
    win_vec_t          win_reg;
    logic              wr_en;
    logic [RIDX_W-1:0] ridx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign ridx   = paddr[APB_AW-1:2];

    // Register writes complete in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                rate_reg[i] <= RATE_RESET;
                win_reg[i]  <= WIN_RESET;
            end
        end
        else if (wr_en)
        begin
            case (ridx)
                REG_RATE0: rate_reg[0] <= pwdata[RATE_W-1:0];
                REG_WIN0:  win_reg[0]  <= pwdata[WIN_W-1:0];
                REG_RATE1: rate_reg[1] <= pwdata[RATE_W-1:0];
                REG_WIN1:  win_reg[1]  <= pwdata[WIN_W-1:0];
                REG_RATE2: rate_reg[2] <= pwdata[RATE_W-1:0];
                REG_WIN2:  win_reg[2]  <= pwdata[WIN_W-1:0];
                REG_RATE3: rate_reg[3] <= pwdata[RATE_W-1:0];
                REG_WIN3:  win_reg[3]  <= pwdata[WIN_W-1:0];
                default:   ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (ridx)
            REG_RATE0: prdata = APB_DW'(rate_reg[0]);
            REG_WIN0:  prdata = APB_DW'(win_reg[0]);
            REG_RATE1: prdata = APB_DW'(rate_reg[1]);
            REG_WIN1:  prdata = APB_DW'(win_reg[1]);
            REG_RATE2: prdata = APB_DW'(rate_reg[2]);
            REG_WIN2:  prdata = APB_DW'(win_reg[2]);
            REG_RATE3: prdata = APB_DW'(rate_reg[3]);
            REG_WIN3:  prdata = APB_DW'(win_reg[3]);
            default:   prdata = '0;
        endcase
    end

    assign rate_vec = rate_reg;
    assign win_vec  = win_reg;

endmodule

// ----- design/ktbl_dp.sv -----
// Datapath: bucket memory, key table, shared multiplier and divider, result registers.
module ktbl_dp
    import ktbl_pkg::*;
#(
    parameter int NUM_KEYS     = 256,
    parameter int NUM_COUNTERS = 4,
    parameter int FRAC_BITS    = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [CMD_W-1:0]   command,
    input  logic [SEL_W-1:0]   counter_sel,
    input  logic [KEY_W-1:0]   key_slot,
    input  logic [NOW_W-1:0]   now_us,
    input  logic [AMT_W-1:0]   amount,
    input  rate_vec_t          rate_vec,
    input  win_vec_t           win_vec,
    output logic [RES_W-1:0]   result_value,
    output logic [STAT_W-1:0]  status,
    output logic [TAKEN_W-1:0] units_taken
);

    localparam int KEYS_USED = (NUM_KEYS < 256) ? NUM_KEYS : 256;
    localparam int KIDX_W    = $clog2(KEYS_USED);
    localparam int ENTRIES   = KEYS_USED * NUM_COUNTERS;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int A_W       = RATE_W + FRAC_BITS;
    localparam int NEED_W    = AMT_W + FRAC_BITS;
    localparam int WUS_W     = WIN_W + 10;
    localparam int D_W       = (A_W > WUS_W) ? A_W : WUS_W;
    localparam int QW        = A_W;
    localparam int MA_W      = (NEED_W > WUS_W) ? NEED_W : WUS_W;
    localparam int NCH       = (MA_W + 15) / 16;
    localparam int MAP_W     = NCH * 16;
    localparam int P_W       = MA_W + 32;
    localparam int MC_W      = $clog2(NCH + 1);
    localparam int DC_W      = $clog2(QW + 1);

    typedef struct packed {
        logic [A_W-1:0]     allow;
        logic [NOW_W-1:0]   last;
        logic [TAKEN_W-1:0] taken;
    } entry_t;

    // Captured request.
    logic [CMD_W-1:0]   cmd_reg;
    logic [SEL_W-1:0]   csel_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [NOW_W-1:0]   now_reg;
    logic [AMT_W-1:0]   amt_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [WIN_W-1:0]   win_reg;
    logic [WUS_W-1:0]   wus_reg;

    // Key table and bucket memory.
    logic [KEYS_USED-1:0] known_reg;
    entry_t               mem [ENTRIES];
    entry_t               mem_q_reg;

    // Multiplier and divider.
    logic [MAP_W-1:0]   mul_a_reg;
    logic [31:0]        mul_b_reg;
    logic [P_W-1:0]     acc_reg;
    logic [MC_W-1:0]    mcnt_reg;
    logic [D_W-1:0]     r_reg;
    logic [QW-1:0]      s_reg;
    logic [QW-1:0]      q_reg;
    logic [D_W-1:0]     d_reg;
    logic [DC_W-1:0]    dcnt_reg;
    logic               ovf_reg;

    // Working values and results.
    logic [A_W-1:0]     na_reg;
    logic [NEED_W-1:0]  def_reg;
    logic [RES_W-1:0]   res_value_reg;
    logic [STAT_W-1:0]  res_status_reg;
    logic [TAKEN_W-1:0] res_taken_reg;

    logic [KIDX_W-1:0]  key_lo;
    logic [IDX_W-1:0]   idx_sel;
    logic [IDX_W-1:0]   idx_new;
    logic [A_W-1:0]     cap;
    logic [NEED_W-1:0]  need;
    logic [NOW_W:0]     el_full;
    logic               el_neg;
    logic               el_full_win;
    logic [A_W:0]       na_sum;
    logic [A_W:0]       na_pre;
    logic               short_fall;
    logic [47:0]        pp;
    logic [P_W-1:0]     acc_hi;
    logic [D_W:0]       div_t;
    logic               div_ge;
    logic [RATE_W-1:0]  new_rate;
    logic [TAKEN_W:0]   taken_add;
    logic [TAKEN_W:0]   taken_sub;
    logic [32:0]        wait_q;
    logic [AMT_W-1:0]   give;
    logic [NEED_W-1:0]  give_fixed;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    entry_t             wr_data;
    logic [RES_W-1:0]   fin_value;
    logic [STAT_W-1:0]  fin_status;
    logic [TAKEN_W-1:0] fin_taken;
    logic               is_ignore;
    logic               is_known;

    // A programmed zero acts as one.
    function automatic logic [RATE_W-1:0] rate_nz(input logic [RATE_W-1:0] r);
        return (r == '0) ? RATE_W'(1) : r;
    endfunction

    function automatic logic [WIN_W-1:0] win_nz(input logic [WIN_W-1:0] w);
        return (w == '0) ? WIN_W'(1) : w;
    endfunction

    // Clamp a grown taken count to the signed 40-bit range.
    function automatic logic [TAKEN_W-1:0] taken_sat(input logic [TAKEN_W:0] s);
        logic [TAKEN_W-1:0] r;
        if (s[TAKEN_W] != s[TAKEN_W-1])
            r = s[TAKEN_W] ? {1'b1, {(TAKEN_W-1){1'b0}}} : {1'b0, {(TAKEN_W-1){1'b1}}};
        else
            r = s[TAKEN_W-1:0];
        return r;
    endfunction

    // Request decode and table indexes.
    assign key_lo    = key_reg[KIDX_W-1:0];
    assign idx_sel   = IDX_W'(int'(key_lo) * NUM_COUNTERS + int'(csel_reg));
    assign idx_new   = IDX_W'(int'(key_lo) * NUM_COUNTERS + int'(cmd.k));
    assign is_ignore = !(cmd_reg == CMD_CONSUME || cmd_reg == CMD_GRANT
                         || cmd_reg == CMD_RELEASE)
                       || (int'(csel_reg) >= NUM_COUNTERS)
                       || (int'(key_reg) >= NUM_KEYS);
    assign is_known  = known_reg[key_lo];
    assign cap       = {rate_reg, {FRAC_BITS{1'b0}}};
    assign need      = {amt_reg, {FRAC_BITS{1'b0}}};
    assign new_rate  = rate_nz(rate_vec[cmd.k]);

    // Elapsed time since the last refill of the stored bucket.
    assign el_full     = {1'b0, now_reg} - {1'b0, mem_q_reg.last};
    assign el_neg      = el_full[NOW_W];
    assign el_full_win = (el_full[NOW_W-1:0] >= NOW_W'(wus_reg));

    // Refilled allowance before the clip at the cap.
    assign na_sum = {1'b0, mem_q_reg.allow} + {1'b0, q_reg};
    always_comb
    begin
        if (el_neg)
            na_pre = {1'b0, mem_q_reg.allow};
        else if (el_full_win)
            na_pre = {1'b0, cap};
        else
            na_pre = na_sum;
    end

    assign short_fall = (NEED_W'(na_reg) < need);

    // One 32x16 partial product per multiplier step.
    assign pp     = mul_b_reg * mul_a_reg[MAP_W-1 -: 16];
    assign acc_hi = acc_reg >> 32;

    // One restoring step per divider cycle.
    assign div_t  = {r_reg, s_reg[QW-1]};
    assign div_ge = (div_t >= {1'b0, d_reg});

    // Status to the controller.
    always_comb
    begin
        stat.ignore      = is_ignore;
        stat.release_op  = (cmd_reg == CMD_RELEASE);
        stat.known       = is_known;
        stat.skip_refill = el_neg || el_full_win;
        stat.throttle    = (cmd_reg == CMD_CONSUME) && short_fall;
        stat.mul_done    = (mcnt_reg == '0);
        stat.div_done    = (dcnt_reg == '0);
        stat.div_ovf     = ovf_reg;
    end

    // Final update of the entry and the result fields.
    assign taken_add = {mem_q_reg.taken[TAKEN_W-1], mem_q_reg.taken}
                       + (TAKEN_W+1)'(amt_reg);
    assign taken_sub = {mem_q_reg.taken[TAKEN_W-1], mem_q_reg.taken}
                       - (TAKEN_W+1)'(amt_reg);
    assign wait_q    = {1'b0, q_reg[31:0]} + 33'(r_reg != '0);
    assign give      = (need > NEED_W'(na_reg)) ? AMT_W'(na_reg >> FRAC_BITS) : amt_reg;
    assign give_fixed = {give, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        wr_en      = 1'b0;
        wr_idx     = idx_sel;
        wr_data    = mem_q_reg;
        fin_value  = '0;
        fin_status = ST_OK;
        fin_taken  = '0;
        if (cmd.op == OP_CREATE)
        begin
            wr_en         = 1'b1;
            wr_idx        = idx_new;
            wr_data.allow = {new_rate, {FRAC_BITS{1'b0}}};
            wr_data.last  = now_reg;
            wr_data.taken = '0;
        end
        else if (cmd.op == OP_FINISH && !is_ignore)
        begin
            case (cmd_reg)
                CMD_RELEASE:
                begin
                    if (!is_known)
                    begin
                        fin_status = ST_UNKNOWN;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_data.taken = taken_sat(taken_sub);
                        fin_taken     = wr_data.taken;
                    end
                end
                CMD_CONSUME:
                begin
                    wr_en         = 1'b1;
                    wr_data.taken = taken_sat(taken_add);
                    fin_taken     = wr_data.taken;
                    if (!short_fall)
                    begin
                        wr_data.allow = A_W'(NEED_W'(na_reg) - need);
                        wr_data.last  = now_reg;
                    end
                    else
                    begin
                        fin_status = ST_THROTTLED;
                        if (ovf_reg || wait_q[32])
                            fin_value = '1;
                        else
                            fin_value = wait_q[31:0];
                    end
                end
                CMD_GRANT:
                begin
                    wr_en         = 1'b1;
                    wr_data.allow = A_W'(NEED_W'(na_reg) - give_fixed);
                    wr_data.last  = now_reg;
                    fin_value     = give;
                    fin_taken     = mem_q_reg.taken;
                end
                default: ;
            endcase
        end
    end

    // Key table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            known_reg <= '0;
        else if (cmd.op == OP_CREATE)
            known_reg[key_lo] <= 1'b1;
    end

    // Bucket memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        if (cmd.op == OP_READ)
            mem_q_reg <= mem[idx_sel];
    end

    // Request capture, arithmetic units and results.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                cmd_reg  <= command;
                csel_reg <= counter_sel;
                key_reg  <= key_slot;
                now_reg  <= now_us;
                amt_reg  <= amount;
                rate_reg <= rate_nz(rate_vec[counter_sel]);
                win_reg  <= win_nz(win_vec[counter_sel]);
                wus_reg  <= WUS_W'(win_nz(win_vec[counter_sel])) * WUS_W'(US_PER_MS);
            end
            OP_MUL_LD_REFILL:
            begin
                mul_a_reg <= MAP_W'(el_full[NOW_W-1:0]);
                mul_b_reg <= 32'(rate_reg);
                acc_reg   <= '0;
                mcnt_reg  <= MC_W'(NCH);
            end
            OP_MUL_LD_WAIT:
            begin
                mul_a_reg <= MAP_W'(def_reg);
                mul_b_reg <= win_reg;
                acc_reg   <= '0;
                mcnt_reg  <= MC_W'(NCH);
            end
            OP_MUL_STEP:
            begin
                acc_reg   <= P_W'({acc_reg, 16'd0}) + P_W'(pp);
                mul_a_reg <= mul_a_reg << 16;
                mcnt_reg  <= mcnt_reg - 1'b1;
            end
            OP_DIV_LD_REFILL:
            begin
                r_reg    <= D_W'(acc_reg >> RATE_W);
                s_reg    <= {acc_reg[RATE_W-1:0], {FRAC_BITS{1'b0}}};
                d_reg    <= D_W'(wus_reg);
                q_reg    <= '0;
                dcnt_reg <= DC_W'(QW);
                ovf_reg  <= 1'b0;
            end
            OP_DIV_LD_WAIT:
            begin
                r_reg    <= D_W'(acc_hi);
                s_reg    <= QW'(acc_reg[31:0]) << (QW - 32);
                d_reg    <= D_W'(cap);
                q_reg    <= '0;
                dcnt_reg <= DC_W'(32);
                ovf_reg  <= (acc_hi >= P_W'(cap));
            end
            OP_DIV_STEP:
            begin
                r_reg    <= div_ge ? D_W'(div_t - {1'b0, d_reg}) : D_W'(div_t);
                q_reg    <= {q_reg[QW-2:0], div_ge};
                s_reg    <= s_reg << 1;
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            OP_SETTLE:
            begin
                na_reg <= (na_pre > {1'b0, cap}) ? cap : A_W'(na_pre);
            end
            OP_DECIDE:
            begin
                def_reg <= need - NEED_W'(na_reg);
            end
            OP_FINISH:
            begin
                res_value_reg  <= fin_value;
                res_status_reg <= fin_status;
                res_taken_reg  <= fin_taken;
            end
            default: ;
        endcase
    end

    assign result_value = res_value_reg;
    assign status       = res_status_reg;
    assign units_taken  = res_taken_reg;

endmodule

// ----- design/ktbl_ctrl.sv -----
// Controller: sequences the datapath through one request transaction.
module ktbl_ctrl
    import ktbl_pkg::*;
#(
    parameter int NUM_COUNTERS = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CREATE,
        S_READ,
        S_BRANCH,
        S_MULR_LD,
        S_MULR_RUN,
        S_DIVR_LD,
        S_DIVR_RUN,
        S_SETTLE,
        S_DECIDE,
        S_MULW_LD,
        S_MULW_RUN,
        S_DIVW_LD,
        S_DIVW_RUN,
        S_FINISH
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [SEL_W-1:0] k_reg;
    logic             busy_reg;
    logic             done_reg;

    // Next state and the datapath operation of the current state.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.k      = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.ignore || (stat.release_op && !stat.known))
                    state_next = S_FINISH;
                else if (stat.release_op || stat.known)
                    state_next = S_READ;
                else
                    state_next = S_CREATE;
            end
            S_CREATE:
            begin
                cmd.op = OP_CREATE;
                if (k_reg == SEL_W'(NUM_COUNTERS - 1))
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.op     = OP_READ;
                state_next = S_BRANCH;
            end
            S_BRANCH:
            begin
                if (stat.release_op)
                    state_next = S_FINISH;
                else if (stat.skip_refill)
                    state_next = S_SETTLE;
                else
                    state_next = S_MULR_LD;
            end
            S_MULR_LD:
            begin
                cmd.op     = OP_MUL_LD_REFILL;
                state_next = S_MULR_RUN;
            end
            S_MULR_RUN:
            begin
                if (stat.mul_done)
                    state_next = S_DIVR_LD;
                else
                    cmd.op = OP_MUL_STEP;
            end
            S_DIVR_LD:
            begin
                cmd.op     = OP_DIV_LD_REFILL;
                state_next = S_DIVR_RUN;
            end
            S_DIVR_RUN:
            begin
                if (stat.div_done)
                    state_next = S_SETTLE;
                else
                    cmd.op = OP_DIV_STEP;
            end
            S_SETTLE:
            begin
                cmd.op     = OP_SETTLE;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.op     = OP_DECIDE;
                state_next = stat.throttle ? S_MULW_LD : S_FINISH;
            end
            S_MULW_LD:
            begin
                cmd.op     = OP_MUL_LD_WAIT;
                state_next = S_MULW_RUN;
            end
            S_MULW_RUN:
            begin
                if (stat.mul_done)
                    state_next = S_DIVW_LD;
                else
                    cmd.op = OP_MUL_STEP;
            end
            S_DIVW_LD:
            begin
                cmd.op     = OP_DIV_LD_WAIT;
                state_next = S_DIVW_RUN;
            end
            S_DIVW_RUN:
            begin
                if (stat.div_ovf || stat.div_done)
                    state_next = S_FINISH;
                else
                    cmd.op = OP_DIV_STEP;
            end
            S_FINISH:
            begin
                cmd.op     = OP_FINISH;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, sweep counter and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FINISH);
            if (state_reg == S_CHECK)
                k_reg <= '0;
            else if (state_reg == S_CREATE)
                k_reg <= k_reg + 1'b1;
            if (state_reg == S_IDLE && start)
                busy_reg <= 1'b1;
            else if (state_reg == S_FINISH)
                busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- design/ktbl_chk.sv -----
// Port-level checker for the limiter, bound to the top level.
module ktbl_chk
    import ktbl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [RES_W-1:0]   result_value,
    input logic [STAT_W-1:0]  status,
    input logic [TAKEN_W-1:0] units_taken
);

    // An accepted transaction keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // No result in the cycle right after a transaction is accepted.
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobe too early");

    // A result is shown only once the block has gone idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A result marks the end of a busy period.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction");

    // An unknown-key release returns zero value and count.
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_UNKNOWN) |-> (result_value == '0 && units_taken == '0))
        else $error("unknown release with nonzero fields");

endmodule

bind keyed_token_bucket_limiter ktbl_chk u_ktbl_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .result_value (result_value),
    .status       (status),
    .units_taken  (units_taken)
);
